@@ design/rmv_pkg.sv @@
// ----------------------------------------------------------------------------
// rmv_pkg
// Shared widths, register map and reset values of the running mean/variance core.
// ----------------------------------------------------------------------------
package rmv_pkg;

    localparam int DATA_W      = 32;
    localparam int WIDE_W      = 64;
    localparam int SLOTS_DEF   = 16;
    localparam int FRAC_DEF    = 16;
    localparam int ADDR_W      = 3;

    localparam logic [0:0] REG_WARMUP   = 1'b0;
    localparam logic [0:0] REG_FALLBACK = 1'b1;

    localparam logic [DATA_W-1:0] WARMUP_RST   = 32'd1000;
    localparam logic [DATA_W-1:0] FALLBACK_RST = 32'd655;

endpackage

@@ design/rmv_div.sv @@
// ----------------------------------------------------------------------------
// rmv_div
// Restoring divider, 64-bit dividend by 32-bit divisor, one quotient bit a cycle.
// ----------------------------------------------------------------------------
module rmv_div import rmv_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [WIDE_W-1:0] i_dividend,
    input  logic [DATA_W-1:0] i_divisor,
    output logic              o_done,
    output logic [WIDE_W-1:0] o_quotient
);

    logic              r_busy;
    logic              r_done;
    logic [5:0]        r_cnt;
    logic [DATA_W-1:0] r_rem;
    logic [DATA_W-1:0] r_dvs;
    logic [WIDE_W-1:0] r_quo;
    logic [DATA_W:0]   w_trial;
    logic              w_ge;

    assign w_trial = {r_rem, r_quo[WIDE_W-1]};
    assign w_ge    = (w_trial >= {1'b0, r_dvs});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= 6'd63;
            end else if (r_busy) begin
                r_cnt <= r_cnt - 6'd1;
                if (r_cnt == 6'd0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_dividend;
            r_rem <= '0;
            r_dvs <= i_divisor;
        end else if (r_busy) begin
            if (w_ge) begin
                r_rem <= DATA_W'(w_trial - {1'b0, r_dvs});
            end else begin
                r_rem <= w_trial[DATA_W-1:0];
            end
            r_quo <= {r_quo[WIDE_W-2:0], w_ge};
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;

endmodule

@@ design/running_mean_variance_core.sv @@
// ----------------------------------------------------------------------------
// running_mean_variance_core
// Per-slot running mean and unbiased sample variance with warm-up batch start.
// ----------------------------------------------------------------------------
// One transaction is worked on at a time. Its result is held in an output
// register, so the next transaction is taken while that result waits; the core
// stalls at write-back only while an earlier result has not been taken. A
// warm-up item is shorter. An item that forms statistics (batch start or
// recursive update) makes two passes of the serial divider at one quotient bit
// per cycle, and the single 32x32 multiplier forms each partial product in a
// state of its own.
module running_mean_variance_core import rmv_pkg::*; #(
    parameter int SLOTS     = SLOTS_DEF,
    parameter int FRAC_BITS = FRAC_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready,
    input  logic              i_valid,
    output logic              o_ready,
    input  logic [3:0]        i_slot,
    input  logic [31:0]       i_iteration,
    input  logic signed [31:0] i_sample_value,
    input  logic              i_included,
    output logic              o_valid,
    input  logic              i_ready,
    output logic [3:0]        o_out_slot,
    output logic signed [31:0] o_mean,
    output logic [31:0]       o_variance,
    output logic [31:0]       o_count
);

    localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;

    localparam logic [3:0] S_IDLE = 4'd0,  S_SQX = 4'd1,  S_UPD = 4'd2,  S_DEC  = 4'd3,
                           S_R1   = 4'd4,  S_R2  = 4'd5,  S_R3  = 4'd6,  S_R4   = 4'd7,
                           S_R5   = 4'd8,  S_DVM = 4'd9,  S_V1  = 4'd10, S_V2   = 4'd11,
                           S_V3   = 4'd12, S_DVV = 4'd13, S_WB  = 4'd14;

    localparam logic [WIDE_W-1:0] SMAX = {1'b0, {(WIDE_W-1){1'b1}}};
    localparam logic [WIDE_W-1:0] SMIN = {1'b1, {(WIDE_W-1){1'b0}}};

    logic [DATA_W-1:0] r_warmup, r_fallback;

    logic [DATA_W-1:0] r_cnt_st  [SLOTS];
    logic [WIDE_W-1:0] r_sum_st  [SLOTS];
    logic [WIDE_W-1:0] r_ssum_st [SLOTS];
    logic [DATA_W-1:0] r_mean_st [SLOTS];
    logic [DATA_W-1:0] r_var_st  [SLOTS];

    logic [3:0]        r_state, n_state;
    logic [3:0]        r_slot;
    logic [31:0]       r_iter;
    logic [31:0]       r_x;
    logic              r_inc;
    logic              r_zero;
    logic              r_ovalid;

    logic [DATA_W-1:0] r_cnt, r_mean, r_var, r_old_mean;
    logic [WIDE_W-1:0] r_sum, r_ssum, r_sqx, r_t, r_plo, r_q, r_dmag;
    logic              r_neg;

    logic [31:0]       w_ma, w_mb;
    logic [WIDE_W-1:0] w_prod;
    logic [DATA_W-1:0] w_absx, w_absom, w_absm, w_nm1, w_nm2;
    logic [7:0]        w_slot_ext;
    logic [IDX_W-1:0]  w_idx;
    logic              w_slot_ok;
    logic [32:0]       w_iter1, w_wl;
    logic [WIDE_W-1:0] w_sum_new, w_xs, w_comb, w_d, w_snum;
    logic [WIDE_W:0]   w_ssum_add, w_comb_add, w_q1, w_q2;
    logic              w_comb_sat;
    logic              w_div_start, w_div_done;
    logic [WIDE_W-1:0] w_dvd, w_quo;
    logic [DATA_W-1:0] w_dvs;
    logic              w_batch;
    logic              w_out_free;

    assign pready = 1'b1;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_warmup   <= WARMUP_RST;
            r_fallback <= FALLBACK_RST;
        end else if (psel && penable && pwrite) begin
            unique case (paddr[2])
                REG_WARMUP:   r_warmup   <= pwdata;
                REG_FALLBACK: r_fallback <= pwdata;
                default:      ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[2])
            REG_WARMUP:   prdata = r_warmup;
            REG_FALLBACK: prdata = r_fallback;
            default:      prdata = '0;
        endcase
    end

    assign w_slot_ext = {4'b0, r_slot};
    assign w_idx      = w_slot_ext[IDX_W-1:0];
    assign w_slot_ok  = ({1'b0, w_slot_ext} < 9'(SLOTS));

    assign w_absx  = r_x[31] ? (~r_x + 32'd1) : r_x;
    assign w_absom = r_old_mean[31] ? (~r_old_mean + 32'd1) : r_old_mean;
    assign w_absm  = r_mean[31] ? (~r_mean + 32'd1) : r_mean;
    assign w_nm1   = r_cnt - 32'd1;
    assign w_nm2   = r_cnt - 32'd2;
    assign w_iter1 = {1'b0, r_iter} + 33'd1;
    assign w_wl    = {1'b0, r_warmup};
    assign w_xs    = {{32{r_x[31]}}, r_x};

    // the output register is free when empty or being taken this cycle
    assign w_out_free = !r_ovalid || i_ready;

    // shared multiplier operand select
    always_comb begin
        w_ma = '0;
        w_mb = '0;
        case (r_state)
            S_SQX: begin w_ma = w_absx;  w_mb = w_absx;       end
            S_R1:  begin w_ma = w_nm1;   w_mb = w_absom;      end
            S_R2:  begin w_ma = w_absom; w_mb = w_absom;      end
            S_R3:  begin w_ma = w_nm1;   w_mb = r_t[31:0];    end
            S_R4:  begin w_ma = w_nm1;   w_mb = r_t[63:32];   end
            S_R5:  begin w_ma = r_var;   w_mb = w_nm2;        end
            S_V1:  begin w_ma = w_absm;  w_mb = w_absm;       end
            S_V2:  begin w_ma = r_cnt;   w_mb = r_t[31:0];    end
            S_V3:  begin w_ma = r_cnt;   w_mb = r_t[63:32];   end
            default: ;
        endcase
    end
    assign w_prod = WIDE_W'(w_ma) * WIDE_W'(w_mb);

    // saturating sums
    assign w_sum_new  = r_sum + w_xs;
    assign w_ssum_add = {1'b0, r_ssum} + {1'b0, r_sqx};
    assign w_comb_add = {1'b0, r_plo} + {1'b0, w_prod[31:0], 32'b0};
    assign w_comb_sat = (w_prod[63:32] != 32'd0) || w_comb_add[WIDE_W];
    assign w_comb     = w_comb_sat ? '1 : w_comb_add[WIDE_W-1:0];
    assign w_q1       = {1'b0, r_q} + {1'b0, w_prod};
    assign w_q2       = {1'b0, (w_q1[WIDE_W] ? {WIDE_W{1'b1}} : w_q1[WIDE_W-1:0])}
                        + {1'b0, r_sqx};
    assign w_d        = (r_q > w_comb) ? (r_q - w_comb) : '0;
    assign w_snum     = (r_old_mean[31] ? (~w_prod + 64'd1) : w_prod) + w_xs;

    // batch path decision, made in DEC from the updated count
    always_comb begin
        w_batch = 1'b0;
        if (w_slot_ok) begin
            if (w_iter1 == w_wl) begin
                w_batch = (r_cnt > 32'd1);
            end else if (w_iter1 > w_wl) begin
                w_batch = r_inc && (r_cnt == 32'd2);
            end
        end
    end

    // divider hookup
    always_comb begin
        w_div_start = 1'b0;
        w_dvd       = r_dmag;
        w_dvs       = r_cnt;
        case (r_state)
            S_DEC: begin
                w_div_start = w_batch;
                w_dvd       = r_sum[63] ? (~r_sum + 64'd1) : r_sum;
            end
            S_R5:  w_div_start = 1'b1;
            S_V3: begin
                w_div_start = 1'b1;
                w_dvd       = w_d;
                w_dvs       = w_nm1;
            end
            default: ;
        endcase
    end

    rmv_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (w_dvd),
        .i_divisor  (w_dvs),
        .o_done     (w_div_done),
        .o_quotient (w_quo)
    );

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: if (i_valid) n_state = S_SQX;
            S_SQX:  n_state = S_UPD;
            S_UPD:  n_state = S_DEC;
            S_DEC: begin
                if (w_batch) begin
                    n_state = S_DVM;
                end else if (w_slot_ok && (w_iter1 > w_wl) && r_inc && (r_cnt > 32'd2)) begin
                    n_state = S_R1;
                end else begin
                    n_state = S_WB;
                end
            end
            S_R1:   n_state = S_R2;
            S_R2:   n_state = S_R3;
            S_R3:   n_state = S_R4;
            S_R4:   n_state = S_R5;
            S_R5:   n_state = S_DVM;
            S_DVM:  if (w_div_done) n_state = S_V1;
            S_V1:   n_state = S_V2;
            S_V2:   n_state = S_V3;
            S_V3:   n_state = S_DVV;
            S_DVV:  if (w_div_done) n_state = S_WB;
            S_WB:   if (w_out_free) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (r_state == S_WB && w_out_free) begin
            r_ovalid <= 1'b1;
        end else if (i_ready) begin
            r_ovalid <= 1'b0;
        end
    end

    // per-slot statistics
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 0; s < SLOTS; s++) begin
                r_cnt_st[s]  <= '0;
                r_sum_st[s]  <= '0;
                r_ssum_st[s] <= '0;
                r_mean_st[s] <= '0;
                r_var_st[s]  <= '0;
            end
        end else if (r_state == S_WB && !r_zero) begin
            r_cnt_st[w_idx]  <= r_cnt;
            r_sum_st[w_idx]  <= r_sum;
            r_ssum_st[w_idx] <= r_ssum;
            r_mean_st[w_idx] <= r_mean;
            r_var_st[w_idx]  <= r_var;
        end
    end

    // working datapath
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                r_slot <= i_slot;
                r_iter <= i_iteration;
                r_x    <= i_sample_value;
                r_inc  <= i_included;
            end
            S_SQX: begin
                r_sqx      <= w_prod >> FRAC_BITS;
                r_zero     <= !w_slot_ok;
                r_cnt      <= r_cnt_st[w_idx];
                r_sum      <= r_sum_st[w_idx];
                r_ssum     <= r_ssum_st[w_idx];
                r_mean     <= r_mean_st[w_idx];
                r_old_mean <= r_mean_st[w_idx];
                r_var      <= r_var_st[w_idx];
            end
            S_UPD: begin
                if (r_inc) begin
                    if (r_cnt != '1) r_cnt <= r_cnt + 32'd1;
                    if (r_sum[63] == r_x[31] && w_sum_new[63] != r_sum[63]) begin
                        r_sum <= r_x[31] ? SMIN : SMAX;
                    end else begin
                        r_sum <= w_sum_new;
                    end
                    r_ssum <= w_ssum_add[WIDE_W] ? '1 : w_ssum_add[WIDE_W-1:0];
                end
            end
            S_DEC: begin
                r_q     <= r_ssum;
                r_neg   <= r_sum[63];
                if (w_slot_ok && !w_batch) begin
                    if (w_iter1 == w_wl) begin
                        r_mean <= '0;
                        r_var  <= r_fallback;
                    end else if (w_iter1 > w_wl && r_cnt < 32'd2) begin
                        r_mean <= '0;
                        if (r_inc) r_var <= r_fallback;
                    end
                end
            end
            S_R1: begin
                r_neg  <= w_snum[63];
                r_dmag <= w_snum[63] ? (~w_snum + 64'd1) : w_snum;
            end
            S_R2: r_t   <= w_prod >> FRAC_BITS;
            S_R3: r_plo <= w_prod;
            S_R4: r_q   <= w_comb;
            S_R5: r_q   <= w_q2[WIDE_W] ? '1 : w_q2[WIDE_W-1:0];
            S_DVM: begin
                if (w_div_done) begin
                    if (r_neg) begin
                        r_mean <= (w_quo > 64'h80000000) ? 32'h80000000
                                                         : (~w_quo[31:0] + 32'd1);
                    end else begin
                        r_mean <= (w_quo > 64'h7FFFFFFF) ? 32'h7FFFFFFF : w_quo[31:0];
                    end
                end
            end
            S_V1: r_t   <= w_prod >> FRAC_BITS;
            S_V2: r_plo <= w_prod;
            S_DVV: begin
                if (w_div_done) begin
                    r_var <= (w_quo[63:32] != 32'd0) ? '1 : w_quo[31:0];
                end
            end
            S_WB: begin
                // hold until the previous result has been taken
                if (w_out_free) begin
                    o_out_slot <= r_slot;
                    o_mean     <= r_zero ? '0 : r_mean;
                    o_variance <= r_zero ? '0 : r_var;
                    o_count    <= r_zero ? '0 : r_cnt;
                end
            end
            default: ;
        endcase
    end

    assign o_ready = (r_state == S_IDLE);
    assign o_valid = r_ovalid;

endmodule
